/* rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sha256_pkg;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_item_t;

  typedef struct packed {
    logic start;
  } round_ctl_t;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenPos = 56;
  localparam int unsigned Rounds = 64;
  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [255:0] InitHash = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_const(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

/* rtl/sha256_round.sv */
`timescale 1ns / 1ps
`default_nettype none
// One SHA-256 round per cycle over a 16-word schedule window.
module sha256_round (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sha256_pkg::round_ctl_t ctl_i,
  input  wire logic [511:0]           block_i,
  input  wire logic [255:0]           chain_i,
  output logic                        done_o,
  output logic [255:0]                chain_o
);
  import sha256_pkg::*;

  logic [511:0] w_q;
  logic [255:0] v_q;
  logic [5:0]   rnd_q;
  logic         run_q;

  logic [31:0] a, b, c, d, e, f, g, h, wt, w1, w14, w9, w0, s0, s1, t1, t2, wn;

  always_comb begin
    {a, b, c, d, e, f, g, h} = v_q;
    wt  = w_q[511:480];
    w0  = w_q[511:480];
    w1  = w_q[479:448];
    w9  = w_q[223:192];
    w14 = w_q[63:32];
    s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    wn  = s1 + w9 + s0 + w0;
    t1  = h + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
        + ((e & f) ^ (~e & g)) + round_const(rnd_q) + wt;
    t2  = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
        + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      rnd_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= run_q && (rnd_q == 6'(Rounds - 1));
      if (ctl_i.start) begin
        run_q <= 1'b1;
        rnd_q <= '0;
      end else if (run_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'(Rounds - 1)) run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      w_q <= block_i;
      v_q <= chain_i;
    end else if (run_q) begin
      w_q <= {w_q[479:0], wn};
      v_q <= {t1 + t2, a, b, c, d + t1, e, f, g};
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      chain_o[32*i +: 32] = chain_i[32*i +: 32] + v_q[32*i +: 32];
    end
  end

endmodule
`default_nettype wire

/* rtl/sha256_stream_hasher_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// SHA-256 hasher that takes a message one byte per input transfer. A byte
// transfer that completes a 64-byte block keeps the input stalled through
// StWait and the 64 compression rounds (one round per cycle in a single
// shared round unit) until the registered done; other data bytes do not. An
// end-of-message transfer pads the message, runs one compression or two when
// 56 or more bytes are pending (or when its own byte completes a block), then
// presents the digest as four 64-bit big-endian output transfers, index 0
// first, with last_word on the fourth. The input is not ready until the
// fourth word has been taken; the hash state then returns to its initial
// value for the next message. The block buffer is a plain register array
// with no clearing after reset; the 0x80 marker, the zero fill and the bit
// length are laid over the buffered bytes on their way into the round unit,
// so bytes beyond the fill count are never used.
module sha256_stream_hasher_core (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire sha256_pkg::in_item_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output sha256_pkg::out_item_t      out_data_o
);
  import sha256_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StComp = 3'd1;
  localparam logic [2:0] StWait = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;

  logic [2:0]   state_q;
  logic [7:0]   buf_q [BlockBytes];
  logic [5:0]   fill_q;
  logic [63:0]  bits_q;
  logic [255:0] chain_q;
  logic         fin_q;       // finishing a message
  logic         pad_q;       // the block being compressed carries padding
  logic         len_only_q;  // the block being compressed holds only the length
  logic [1:0]   idx_q;

  logic [511:0] block;
  logic [255:0] chain_new;
  logic         done;
  round_ctl_t   ctl;
  logic         in_fire, out_fire;
  logic         full_block;
  logic [63:0]  total;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_fire    = out_valid_o && out_ready_i;
  assign full_block  = in_data_i.byte_present && (fill_q == 6'(BlockBytes - 1));
  assign total       = bits_q + {55'd0, fill_q, 3'd0};

  // Block as seen by the round unit. A data block passes the buffer through.
  // A padded block keeps the pending bytes, puts the marker right after them,
  // zeros the rest and ends in the big-endian bit length when it fits. The
  // length-only block that follows a long tail is zeros and the length.
  always_comb begin
    for (int i = 0; i < BlockBytes; i++) begin
      if (!pad_q || (!len_only_q && 6'(i) < fill_q)) begin
        block[511 - 8*i -: 8] = buf_q[i];
      end else if (!len_only_q && 6'(i) == fill_q) begin
        block[511 - 8*i -: 8] = PadByte;
      end else if (i >= LenPos && (len_only_q || fill_q < 6'(LenPos))) begin
        block[511 - 8*i -: 8] = total[8*(BlockBytes-1-i) +: 8];
      end else begin
        block[511 - 8*i -: 8] = 8'h00;
      end
    end
  end

  assign ctl.start = (state_q == StWait);

  sha256_round u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .block_i (block),
    .chain_i (chain_q),
    .done_o  (done),
    .chain_o (chain_new)
  );

  // StWait launches the round unit, StComp waits for it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      fill_q     <= '0;
      bits_q     <= '0;
      chain_q    <= InitHash;
      fin_q      <= 1'b0;
      pad_q      <= 1'b0;
      len_only_q <= 1'b0;
      idx_q      <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (in_fire) begin
            if (in_data_i.byte_present) begin
              fill_q <= fill_q + 6'd1;
              if (fill_q == 6'(BlockBytes - 1)) begin
                bits_q  <= bits_q + 64'd512;
              end
            end
            fin_q      <= in_data_i.end_of_message;
            // A completed data block goes first; padding follows it.
            pad_q      <= in_data_i.end_of_message && !full_block;
            len_only_q <= 1'b0;
            if (full_block || in_data_i.end_of_message) begin
              state_q <= StWait;
            end
          end
        end
        StWait: state_q <= StComp;
        StComp: begin
          if (done) begin
            chain_q <= chain_new;
            if (!fin_q) begin
              state_q <= StIdle;
            end else if (!pad_q) begin
              pad_q   <= 1'b1;
              state_q <= StWait;
            end else if (!len_only_q && fill_q >= 6'(LenPos)) begin
              len_only_q <= 1'b1;
              state_q    <= StWait;
            end else begin
              state_q <= StOut;
              idx_q   <= '0;
            end
          end
        end
        StOut: begin
          if (out_fire) begin
            idx_q <= idx_q + 2'd1;
            if (idx_q == 2'd3) begin
              state_q    <= StIdle;
              fill_q     <= '0;
              bits_q     <= '0;
              chain_q    <= InitHash;
              fin_q      <= 1'b0;
              pad_q      <= 1'b0;
              len_only_q <= 1'b0;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.byte_present) buf_q[fill_q] <= in_data_i.message_byte;
  end

  assign out_data_o.digest_word = chain_q[255 - 64*idx_q -: 64];
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == 2'd3);

  a_no_out_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("input and output both open");
  a_last_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && out_data_o.last_word |=> in_ready_o) else $error("no return to idle");
  a_idx_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> idx_q == 2'd0) else $error("digest not from word 0");

endmodule
`default_nettype wire
